FILE: hw/rtl/spt_pkg.sv
// Package for the swing pivot tracker: channel payload types, ring entry,
// scanner request and result records, and the control state type.
// No dependencies.
`default_nettype none

package spt_pkg;

  localparam int PRICE_W = 32;
  localparam int TIME_W  = 41;
  localparam int SEQ_W   = 32;

  // bars needed ahead of the current one before a swing can be tested
  localparam logic [1:0] SEEN_FULL = 2'd2;
  // fewest ring entries that can hold an interior pivot
  localparam int PIVOT_MIN = 3;

  typedef struct packed {
    logic [PRICE_W-1:0] bar_high;
    logic [PRICE_W-1:0] bar_low;
    logic [TIME_W-1:0]  bar_time;
    logic [SEQ_W-1:0]   bar_seq;
  } spt_in_t;

  typedef struct packed {
    logic               new_high_valid;
    logic [PRICE_W-1:0] new_high_price;
    logic               new_low_valid;
    logic [PRICE_W-1:0] new_low_price;
    logic [TIME_W-1:0]  pivot_time;
    logic [SEQ_W-1:0]   pivot_seq;
    logic               mid_high_valid;
    logic [PRICE_W-1:0] mid_high_price;
    logic [TIME_W-1:0]  mid_high_time;
    logic               mid_low_valid;
    logic [PRICE_W-1:0] mid_low_price;
    logic [TIME_W-1:0]  mid_low_time;
  } spt_out_t;

  // one retained swing
  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic [TIME_W-1:0]  tstamp;
  } spt_entry_t;

  // append request into a ring
  typedef struct packed {
    logic       en;
    spt_entry_t ent;
  } spt_push_t;

  // scan result, done pulses for one cycle
  typedef struct packed {
    logic       done;
    logic       found;
    spt_entry_t ent;
  } spt_pivot_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } spt_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/spt_chan_if.sv
// Valid/ready channel interface used for both the bar input and result output.
// Payload type is a parameter; types come from spt_pkg at the instance.
`default_nettype none

interface spt_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport src (output valid, output data, input ready);
  modport snk (input valid, input data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/spt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module spt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/spt_scan.sv
// One swing ring: RAM of retained swings, head/count, and the backward scan
// that finds the newest interior pivot. Depends on spt_pkg and spt_ram.
`default_nettype none

module spt_scan #(
  parameter int RETAIN = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               is_high,
  input  wire spt_pkg::spt_push_t push,
  input  wire logic               start,
  output spt_pkg::spt_pivot_t     piv
);
  import spt_pkg::*;

  localparam int AW = $clog2(RETAIN);
  localparam int CW = $clog2(RETAIN + 1);
  localparam int EW = $bits(spt_entry_t);

  logic [AW-1:0]      head_r;
  logic [CW-1:0]      count_r;
  logic [AW-1:0]      rd_ptr_r;
  logic [CW-1:0]      left_r;
  logic               busy_r;
  logic               rvld_r;
  logic               last_r;
  logic [1:0]         fill_r;
  spt_entry_t         mid_r;
  logic [PRICE_W-1:0] newer_r;
  spt_pivot_t         piv_r;

  logic [EW-1:0] rdata;
  spt_entry_t    rd_ent;
  logic          beyond_newer;
  logic          beyond_older;
  logic          hit;
  logic          finish;
  logic          re;

  // ring storage
  spt_ram #(
    .WIDTH (EW),
    .DEPTH (RETAIN)
  ) u_ram (
    .clk   (clk),
    .we    (push.en),
    .waddr (head_r),
    .wdata (push.ent),
    .re    (re),
    .raddr (rd_ptr_r),
    .rdata (rdata)
  );

  assign rd_ent = spt_entry_t'(rdata);

  // window test: mid_r against its newer neighbor and the entry just read
  always_comb begin
    if (is_high) begin
      beyond_newer = mid_r.price > newer_r;
      beyond_older = mid_r.price > rd_ent.price;
    end else begin
      beyond_newer = mid_r.price < newer_r;
      beyond_older = mid_r.price < rd_ent.price;
    end
    hit    = rvld_r && (fill_r == 2'd2) && beyond_newer && beyond_older;
    finish = hit || (rvld_r && last_r);
    re     = busy_r && (left_r != '0) && !finish;
  end

  // append, then scan newest to oldest one read per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
      busy_r  <= 1'b0;
      rvld_r  <= 1'b0;
      last_r  <= 1'b0;
      fill_r  <= '0;
      piv_r   <= '0;
    end else begin
      piv_r.done <= 1'b0;

      if (push.en) begin
        head_r <= (head_r == AW'(RETAIN - 1)) ? '0 : head_r + 1'b1;
        if (count_r != CW'(RETAIN)) begin
          count_r <= count_r + 1'b1;
        end
      end

      if (start) begin
        if (count_r < CW'(PIVOT_MIN)) begin
          piv_r.done  <= 1'b1;
          piv_r.found <= 1'b0;
        end else begin
          busy_r   <= 1'b1;
          rd_ptr_r <= (head_r == '0) ? AW'(RETAIN - 1) : head_r - 1'b1;
          left_r   <= count_r;
          fill_r   <= '0;
          rvld_r   <= 1'b0;
        end
      end else if (busy_r) begin
        if (re) begin
          rd_ptr_r <= (rd_ptr_r == '0) ? AW'(RETAIN - 1) : rd_ptr_r - 1'b1;
          left_r   <= left_r - 1'b1;
          rvld_r   <= 1'b1;
          last_r   <= (left_r == CW'(1));
        end else begin
          rvld_r <= 1'b0;
        end

        if (rvld_r) begin
          newer_r <= mid_r.price;
          mid_r   <= rd_ent;
          if (fill_r != 2'd2) begin
            fill_r <= fill_r + 1'b1;
          end
        end

        if (finish) begin
          busy_r      <= 1'b0;
          rvld_r      <= 1'b0;
          piv_r.done  <= 1'b1;
          piv_r.found <= hit;
          piv_r.ent   <= mid_r;
        end
      end
    end
  end

  assign piv = piv_r;

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(RETAIN))
    else $error("ring count above capacity");
  a_no_push_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !push.en)
    else $error("ring written during scan");
  a_fill_before_hit: assert property (@(posedge clk) disable iff (!rst_n)
    hit |-> $past(rvld_r) && $past(fill_r) != 2'd0)
    else $error("pivot found before window filled");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/swing_pivot_tracker.sv
// Swing pivot tracker top level: bar window, swing test, control and result
// register. Depends on spt_pkg, spt_chan_if and spt_scan.
`default_nettype none

// Takes one closed bar per transfer and returns exactly one result per bar.
// The two previous bars are held in registers. The middle bar is tested as a
// swing high/low when the new bar arrives. Confirmed swings are appended to
// two retained rings of RETAIN entries, each kept in its own RAM with one
// write port and one registered read port. After the append, both rings are
// scanned in parallel from the newest entry backward, one RAM read per cycle,
// until the newest interior pivot is found or the oldest entry is read. A ring
// that holds fewer than three entries is not read at all. The longer of the
// two scans decides when the result is ready. The next bar is taken as soon as
// the result is in the output register, even if it has not been taken yet.
module swing_pivot_tracker #(
  parameter int RETAIN = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  spt_chan_if.snk   in_bus,
  spt_chan_if.src   out_bus
);
  import spt_pkg::*;

  spt_state_t state_r;
  spt_state_t state_nxt;

  logic [1:0]         bars_seen_r;
  logic [PRICE_W-1:0] prev0_high_r, prev1_high_r;
  logic [PRICE_W-1:0] prev0_low_r, prev1_low_r;
  logic [TIME_W-1:0]  prev1_time_r;
  logic               start_r;
  logic               hdone_r, ldone_r;
  spt_out_t           res_r;
  spt_out_t           out_r;
  logic               out_valid_r;

  logic       acc;
  logic       warm;
  logic       new_high;
  logic       new_low;
  logic       in_ready;
  logic       load_out;
  spt_push_t  hpush, lpush;
  spt_pivot_t hpiv, lpiv;

  assign acc  = in_bus.valid && in_ready;
  assign warm = (bars_seen_r == SEEN_FULL);

  // three-bar swing test on the middle bar
  always_comb begin
    new_high = warm && (prev1_high_r > prev0_high_r)
                    && (prev1_high_r > in_bus.data.bar_high);
    new_low  = warm && (prev1_low_r < prev0_low_r)
                    && (prev1_low_r < in_bus.data.bar_low);
    hpush.en         = acc && new_high;
    hpush.ent.price  = prev1_high_r;
    hpush.ent.tstamp = prev1_time_r;
    lpush.en         = acc && new_low;
    lpush.ent.price  = prev1_low_r;
    lpush.ent.tstamp = prev1_time_r;
  end

  spt_scan #(.RETAIN(RETAIN)) u_high (
    .clk     (clk),
    .rst_n   (rst_n),
    .is_high (1'b1),
    .push    (hpush),
    .start   (start_r),
    .piv     (hpiv)
  );

  spt_scan #(.RETAIN(RETAIN)) u_low (
    .clk     (clk),
    .rst_n   (rst_n),
    .is_high (1'b0),
    .push    (lpush),
    .start   (start_r),
    .piv     (lpiv)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (acc) state_nxt = ST_SCAN;
      ST_SCAN: if (hdone_r && ldone_r) state_nxt = ST_HOLD;
      ST_HOLD: if (load_out) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_HOLD: load_out = !out_valid_r || out_bus.ready;
      default: begin
        in_ready = 1'b0;
        load_out = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      bars_seen_r <= '0;
      start_r     <= 1'b0;
      hdone_r     <= 1'b0;
      ldone_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      start_r <= acc;
      if (acc) begin
        hdone_r <= 1'b0;
        ldone_r <= 1'b0;
        if (!warm) begin
          bars_seen_r <= bars_seen_r + 1'b1;
        end
      end else begin
        if (hpiv.done) hdone_r <= 1'b1;
        if (lpiv.done) ldone_r <= 1'b1;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // bar window, result assembly and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev0_high_r <= '0;
      prev1_high_r <= '0;
      prev0_low_r  <= '0;
      prev1_low_r  <= '0;
      prev1_time_r <= '0;
    end else if (acc) begin
      prev0_high_r <= prev1_high_r;
      prev1_high_r <= in_bus.data.bar_high;
      prev0_low_r  <= prev1_low_r;
      prev1_low_r  <= in_bus.data.bar_low;
      prev1_time_r <= in_bus.data.bar_time;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      res_r.new_high_valid <= new_high;
      res_r.new_high_price <= new_high ? prev1_high_r : '0;
      res_r.new_low_valid  <= new_low;
      res_r.new_low_price  <= new_low ? prev1_low_r : '0;
      res_r.pivot_time     <= warm ? prev1_time_r : '0;
      res_r.pivot_seq      <= in_bus.data.bar_seq;
    end
    if (hpiv.done) begin
      res_r.mid_high_valid <= hpiv.found;
      res_r.mid_high_price <= hpiv.found ? hpiv.ent.price : '0;
      res_r.mid_high_time  <= hpiv.found ? hpiv.ent.tstamp : '0;
    end
    if (lpiv.done) begin
      res_r.mid_low_valid <= lpiv.found;
      res_r.mid_low_price <= lpiv.found ? lpiv.ent.price : '0;
      res_r.mid_low_time  <= lpiv.found ? lpiv.ent.tstamp : '0;
    end
    if (load_out) begin
      out_r <= res_r;
    end
  end

  assign in_bus.ready  = in_ready;
  assign out_bus.valid = out_valid_r;
  assign out_bus.data  = out_r;

`ifndef SYNTHESIS
  a_start_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> start_r && state_r == ST_SCAN)
    else $error("scan not started after input transfer");
  a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (hpiv.done || lpiv.done) |-> state_r == ST_SCAN)
    else $error("scan result outside scan phase");
  a_hold_has_both: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_HOLD |-> hdone_r && ldone_r)
    else $error("result held before both scans finished");
  a_swing_warm: assert property (@(posedge clk) disable iff (!rst_n)
    (hpush.en || lpush.en) |-> bars_seen_r == SEEN_FULL)
    else $error("swing confirmed during warm-up");
`endif

endmodule

`default_nettype wire
